[rtl/gvf_pkg.sv]
`default_nettype none
package gvf_pkg;

  localparam int DATA_W     = 32;
  localparam int COEF_W     = 16;
  localparam int SIGMA_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_COEF   = 3;
  localparam int FRAC_SHIFT = 15;

  // Six products of 48 bits each fit in 51 bits.
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int SUM_W      = DATA_W + 5;

  localparam int RAD_W      = DATA_W + 16;
  localparam int REM_W      = SIGMA_W + 2;
  localparam int ROOT_STEPS = SIGMA_W;
  localparam int ROOT_CNT_W = 5;

  localparam logic REQ_PRESAMPLE = 1'b0;
  localparam logic REQ_DATA      = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GARCH_1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GARCH_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GARCH_3   = 3'd6;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] rsq;
    logic [DATA_W-1:0] pvar;
    logic              sat;
  } entry_t;

  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_wr_t;

endpackage
`default_nettype wire

[rtl/gvf_req_if.sv]
`default_nettype none
interface gvf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [gvf_pkg::DATA_W-1:0] residual;
  logic [gvf_pkg::DATA_W-1:0] presample_arch;
  logic [gvf_pkg::DATA_W-1:0] presample_variance;

  modport source (output valid, req_type, residual, presample_arch, presample_variance,
                  input ready);
  modport sink (input valid, req_type, residual, presample_arch, presample_variance,
                output ready);
endinterface
`default_nettype wire

[rtl/gvf_rsp_if.sv]
`default_nettype none
interface gvf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gvf_pkg::DATA_W-1:0]  variance;
  logic [gvf_pkg::SIGMA_W-1:0] sigma;
  logic                        saturated;

  modport source (output valid, variance, sigma, saturated, input ready);
  modport sink (input valid, variance, sigma, saturated, output ready);
endinterface
`default_nettype wire

[rtl/garch_variance_filter_unit.sv]
`default_nettype none
// Channel  Dir  Payload                                                Handshake
// req      in   req_type, residual, presample_arch, presample_variance valid/ready
// rsp      out  variance, sigma, saturated                              valid/ready
// cfg      in   cfg_index, cfg_data                                    cfg_write
//
// A data request passes through the back end as one shared 16x32 multiplier
// over the lag terms, one saturating sum, then a 24-step digit-by-digit
// square root. A presample request goes straight to the square root.
// The front end squares the residual and queues requests, so input stalls only
// when the queue is full. Synchronous reset clears histories, coefficients and
// control state.
module garch_variance_filter_unit #(
  parameter int MAX_ORDER   = 3,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [gvf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gvf_pkg::DATA_W-1:0]    cfg_data,
  gvf_req_if.sink                            req,
  gvf_rsp_if.source                          rsp
);

  gvf_pkg::cfg_wr_t cfg;
  gvf_pkg::entry_t  push_entry;
  logic             push_valid;
  logic             push_ready;
  gvf_pkg::entry_t  pop_entry;
  logic             pop_valid;
  logic             pop_ready;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  gvf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  gvf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  gvf_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

[rtl/gvf_front.sv]
`default_nettype none
module gvf_front (
  input  wire logic       clk,
  input  wire logic       rst,
  gvf_req_if.sink         req,
  output gvf_pkg::entry_t push_entry,
  output logic            push_valid,
  input  wire logic       push_ready
);

  logic                       hold_valid;
  logic                       hold_kind;
  logic [gvf_pkg::DATA_W-1:0] hold_mag;
  logic [gvf_pkg::DATA_W-1:0] hold_pa;
  logic [gvf_pkg::DATA_W-1:0] hold_pv;
  logic [2*gvf_pkg::DATA_W-1:0] sq;
  logic                       sq_ovf;
  logic                       take;
  logic                       push_done;

  assign push_done = hold_valid && push_ready;
  assign req.ready = !hold_valid || push_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push_done) begin
      hold_valid <= 1'b0;
    end
  end

  // Hold the residual magnitude; the most negative value maps to 2^31.
  always_ff @(posedge clk) begin
    if (take) begin
      hold_kind <= req.req_type;
      hold_mag  <= req.residual[gvf_pkg::DATA_W-1] ? (~req.residual + 1'b1) : req.residual;
      hold_pa   <= req.presample_arch;
      hold_pv   <= req.presample_variance;
    end
  end

  assign sq     = {{gvf_pkg::DATA_W{1'b0}}, hold_mag} * {{gvf_pkg::DATA_W{1'b0}}, hold_mag};
  assign sq_ovf = |sq[2*gvf_pkg::DATA_W-1:gvf_pkg::DATA_W+16];

  always_comb begin
    push_entry.kind = hold_kind;
    push_entry.pvar = hold_pv;
    if (hold_kind == gvf_pkg::REQ_DATA) begin
      push_entry.rsq = sq_ovf ? '1 : sq[gvf_pkg::DATA_W+15:16];
      push_entry.sat = sq_ovf;
    end else begin
      push_entry.rsq = hold_pa;
      push_entry.sat = 1'b0;
    end
  end

  assign push_valid = hold_valid;

endmodule
`default_nettype wire

[rtl/gvf_queue.sv]
`default_nettype none
module gvf_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gvf_pkg::entry_t  push_entry,
  input  wire logic             push_valid,
  output logic                  push_ready,
  output gvf_pkg::entry_t       pop_entry,
  output logic                  pop_valid,
  input  wire logic             pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gvf_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[rtl/gvf_back.sv]
`default_nettype none
module gvf_back #(
  parameter int MAX_ORDER = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gvf_pkg::cfg_wr_t cfg,
  input  wire gvf_pkg::entry_t  pop_entry,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  gvf_rsp_if.source             rsp
);

  localparam int NCOEF = (MAX_ORDER < gvf_pkg::NUM_COEF) ? MAX_ORDER : gvf_pkg::NUM_COEF;
  localparam int NTERM = 2 * NCOEF;
  localparam int TW    = $clog2(NTERM + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_SUM  = 5'b00100,
    S_ROOT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [gvf_pkg::DATA_W-1:0] omega;
  logic [gvf_pkg::COEF_W-1:0] arch_coef  [gvf_pkg::NUM_COEF];
  logic [gvf_pkg::COEF_W-1:0] garch_coef [gvf_pkg::NUM_COEF];
  logic [gvf_pkg::DATA_W-1:0] rsq_hist   [MAX_ORDER];
  logic [gvf_pkg::DATA_W-1:0] var_hist   [MAX_ORDER];

  logic [TW-1:0]                  term;
  logic [gvf_pkg::COEF_W-1:0]     cur_coef;
  logic [gvf_pkg::DATA_W-1:0]     cur_hist;
  logic [gvf_pkg::PROD_W-1:0]     prod;
  logic [gvf_pkg::ACC_W-1:0]      acc;
  logic [gvf_pkg::SUM_W-1:0]      total;
  logic                           var_ovf;
  logic [gvf_pkg::DATA_W-1:0]     var_sum;

  logic [gvf_pkg::DATA_W-1:0]     rsq_new;
  logic [gvf_pkg::DATA_W-1:0]     var_r;
  logic                           sat_r;

  logic                           pop_take;
  logic                           hist_push;
  logic [gvf_pkg::DATA_W-1:0]     hist_rsq_in;
  logic [gvf_pkg::DATA_W-1:0]     hist_var_in;

  logic [gvf_pkg::RAD_W-1:0]      rad;
  logic [gvf_pkg::REM_W-1:0]      rem;
  logic [gvf_pkg::SIGMA_W-1:0]    root;
  logic [gvf_pkg::ROOT_CNT_W-1:0] rcnt;
  logic [gvf_pkg::REM_W+1:0]      rem_shift;
  logic [gvf_pkg::REM_W+1:0]      trial;
  logic                           root_bit;

  logic                           out_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= '0;
      for (int k = 0; k < gvf_pkg::NUM_COEF; k++) begin
        arch_coef[k]  <= '0;
        garch_coef[k] <= '0;
      end
    end else if (cfg.write) begin
      unique case (cfg.index)
        gvf_pkg::REG_INTERCEPT: omega         <= cfg.data;
        gvf_pkg::REG_ARCH_1:    arch_coef[0]  <= cfg.data[gvf_pkg::COEF_W-1:0];
        gvf_pkg::REG_ARCH_2:    arch_coef[1]  <= cfg.data[gvf_pkg::COEF_W-1:0];
        gvf_pkg::REG_ARCH_3:    arch_coef[2]  <= cfg.data[gvf_pkg::COEF_W-1:0];
        gvf_pkg::REG_GARCH_1:   garch_coef[0] <= cfg.data[gvf_pkg::COEF_W-1:0];
        gvf_pkg::REG_GARCH_2:   garch_coef[1] <= cfg.data[gvf_pkg::COEF_W-1:0];
        gvf_pkg::REG_GARCH_3:   garch_coef[2] <= cfg.data[gvf_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign pop_ready = (state == S_IDLE);
  assign pop_take  = pop_valid && pop_ready;

  // Select one coefficient and one lag per MAC step
  always_comb begin
    cur_coef = '0;
    cur_hist = '0;
    for (int k = 0; k < NCOEF; k++) begin
      if (term == TW'(k)) begin
        cur_coef = arch_coef[k];
        cur_hist = rsq_hist[k];
      end
      if (term == TW'(k + NCOEF)) begin
        cur_coef = garch_coef[k];
        cur_hist = var_hist[k];
      end
    end
  end

  assign total   = gvf_pkg::SUM_W'(acc >> gvf_pkg::FRAC_SHIFT)
                 + gvf_pkg::SUM_W'(omega);
  assign var_ovf = |total[gvf_pkg::SUM_W-1:gvf_pkg::DATA_W];
  assign var_sum = var_ovf ? '1 : total[gvf_pkg::DATA_W-1:0];

  assign hist_push   = (pop_take && pop_entry.kind == gvf_pkg::REQ_PRESAMPLE)
                     || (state == S_SUM);
  assign hist_rsq_in = (state == S_SUM) ? rsq_new : pop_entry.rsq;
  assign hist_var_in = (state == S_SUM) ? var_sum : pop_entry.pvar;

  // Lag histories, lag one at index zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        rsq_hist[k] <= '0;
        var_hist[k] <= '0;
      end
    end else if (hist_push) begin
      rsq_hist[0] <= hist_rsq_in;
      var_hist[0] <= hist_var_in;
      for (int k = 1; k < MAX_ORDER; k++) begin
        rsq_hist[k] <= rsq_hist[k-1];
        var_hist[k] <= var_hist[k-1];
      end
    end
  end

  // One root bit per step
  assign rem_shift = {rem, rad[gvf_pkg::RAD_W-1:gvf_pkg::RAD_W-2]};
  assign trial     = {2'b00, root, 2'b01};
  assign root_bit  = (rem_shift >= trial);

  assign out_load = (state == S_OUT) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop_take) begin
          state_next = (pop_entry.kind == gvf_pkg::REQ_DATA) ? S_MAC : S_ROOT;
        end
      end
      S_MAC:  if (term == TW'(NTERM)) state_next = S_SUM;
      S_SUM:  state_next = S_ROOT;
      S_ROOT: if (rcnt == gvf_pkg::ROOT_CNT_W'(gvf_pkg::ROOT_STEPS - 1)) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (pop_take) begin
      rsq_new <= pop_entry.rsq;
      sat_r   <= pop_entry.sat;
      term    <= '0;
      acc     <= '0;
    end
    if (state == S_MAC) begin
      prod <= gvf_pkg::PROD_W'(cur_coef) * gvf_pkg::PROD_W'(cur_hist);
      if (term != '0) begin
        acc <= acc + gvf_pkg::ACC_W'(prod);
      end
      term <= term + 1'b1;
    end
    if (state == S_SUM) begin
      sat_r <= sat_r | var_ovf;
    end
    if (hist_push) begin
      var_r <= hist_var_in;
      rad   <= {hist_var_in, 16'b0};
      rem   <= '0;
      root  <= '0;
      rcnt  <= '0;
    end
    if (state == S_ROOT) begin
      rad  <= rad << 2;
      rem  <= root_bit ? gvf_pkg::REM_W'(rem_shift - trial)
                       : gvf_pkg::REM_W'(rem_shift);
      root <= {root[gvf_pkg::SIGMA_W-2:0], root_bit};
      rcnt <= rcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.variance  <= var_r;
      rsp.sigma     <= root;
      rsp.saturated <= sat_r;
    end
  end

endmodule
`default_nettype wire
